// ===== hdl/spindle_synced_step_generator_assert.svh =====
// Assertion macros used by the step generator phase accumulator
`ifndef SPINDLE_SYNCED_STEP_GENERATOR_ASSERT_SVH
`define SPINDLE_SYNCED_STEP_GENERATOR_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define SSSG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define SSSG_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  `SSSG_ASSERT(label, clk, rst_n, (cond) |=> (cons), msg)

`endif

// ===== hdl/sssg_pkg.sv =====
// Types and constants for the spindle synced step generator
`default_nettype none

package sssg_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RampW  = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [DataW-1:0] UnitStep = 32'h0001_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRACK_ENABLE = 2'd0,
    CFG_TARGET_RATIO = 2'd1,
    CFG_RAMP_STEP    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_STEP = 1'b0,
    ACT_RAMP = 1'b1
  } action_e;

  // Work handed from the front stage to the phase accumulator
  typedef struct packed {
    logic             step_en;
    logic [DataW-1:0] prod;
    logic [DataW-1:0] ratio;
  } stage_t;

endpackage

`default_nettype wire

// ===== hdl/spindle_synced_step_generator.sv =====
// Datapath: an accepted word is registered in the front stage, then in the output stage.
// Throughput: one word per cycle while the output is not stalled; the front stage holds
// the 32x32 multiply, the back stage the phase add and step compare.
// Back pressure stalls both stages in place; input ready follows output ready.
// Reset clears configuration, ratio, position, phase state and valid flags to zero.
// Top level: one electronic leadscrew axis locked to a spindle encoder
`default_nettype none

module spindle_synced_step_generator
  import sssg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DataW-1:0]   cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [DataW-1:0]   s_axis_tdata,  // [31:0] spindle_position
  input  wire logic               s_axis_tuser,  // [0] action
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [71:0]             m_axis_tdata   // [0] step_pulse, [1] direction,
                                                 // [33:2] steps_made,
                                                 // [65:34] current_ratio, [71:66] zero
);

  logic             track_q;
  logic [DataW-1:0] target_q;
  logic [RampW-1:0] ramp_q;
  logic [DataW-1:0] prev_q;
  logic [DataW-1:0] ratio_q, ratio_d;
  logic             s1_valid_q;
  stage_t           s1_q, s1_d;
  logic             out_valid_q;
  logic             out_pulse_q;
  logic             out_dir_q;
  logic [DataW-1:0] out_count_q;
  logic [DataW-1:0] out_ratio_q;
  logic             out_ready;
  logic             s1_adv;
  logic             in_acc;
  logic             pulse;
  logic             dir;
  logic [DataW-1:0] count;
  logic [DataW-1:0] delta;
  logic signed [DataW+1:0] cur, tgt, stp, up, dn;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_ready;
  assign s_axis_tready = !s1_valid_q || out_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q  <= 1'b0;
      target_q <= '0;
      ramp_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TRACK_ENABLE: track_q  <= cfg_wdata_i[0];
        CFG_TARGET_RATIO: target_q <= cfg_wdata_i;
        CFG_RAMP_STEP:    ramp_q   <= cfg_wdata_i[RampW-1:0];
        default: ;
      endcase
    end
  end

  // slew ratio toward target (zero when tracking is off), clamp on overshoot; zero ramp step jumps to target
  always_comb begin
    cur = {{2{ratio_q[DataW-1]}}, ratio_q};
    tgt = track_q ? {{2{target_q[DataW-1]}}, target_q} : '0;
    stp = {3'b000, ramp_q};
    up  = cur + stp;
    dn  = cur - stp;
    if (stp == '0) begin
      ratio_d = tgt[DataW-1:0];
    end else if (cur < tgt) begin
      ratio_d = (up > tgt) ? tgt[DataW-1:0] : up[DataW-1:0];
    end else if (cur > tgt) begin
      ratio_d = (dn < tgt) ? tgt[DataW-1:0] : dn[DataW-1:0];
    end else begin
      ratio_d = ratio_q;
    end
  end

  assign delta = s_axis_tdata - prev_q;

  always_comb begin
    s1_d.step_en = (action_e'(s_axis_tuser) == ACT_STEP) && track_q;
    s1_d.prod    = delta * ratio_q;
    s1_d.ratio   = (action_e'(s_axis_tuser) == ACT_RAMP) ? ratio_d : ratio_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      ratio_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        if (action_e'(s_axis_tuser) == ACT_RAMP) begin
          ratio_q <= ratio_d;
        end else begin
          prev_q <= s_axis_tdata;
        end
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  sssg_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s1_adv),
    .work_i  (s1_q),
    .pulse_o (pulse),
    .dir_o   (dir),
    .count_o (count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pulse_q <= pulse;
      out_dir_q   <= dir;
      out_count_q <= count;
      out_ratio_q <= s1_q.ratio;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_ratio_q, out_count_q, out_dir_q, out_pulse_q};

endmodule

`default_nettype wire

// ===== hdl/sssg_phase.sv =====
// Phase accumulator, step decision, step count and direction state
`default_nettype none

`include "spindle_synced_step_generator_assert.svh"

module sssg_phase
  import sssg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire stage_t           work_i,
  output logic                  pulse_o,
  output logic                  dir_o,
  output logic [DataW-1:0]      count_o
);

  logic [DataW-1:0] phase_q, phase_d;
  logic [DataW-1:0] count_q, count_d;
  logic             dir_q, dir_d;
  logic [DataW-1:0] sum;

  always_comb begin
    sum     = phase_q + work_i.prod;
    phase_d = phase_q;
    count_d = count_q;
    dir_d   = dir_q;
    pulse_o = 1'b0;
    if (work_i.step_en) begin
      phase_d = sum;
      if ($signed(sum) >= $signed(UnitStep)) begin
        pulse_o = 1'b1;
        dir_d   = 1'b1;
        count_d = count_q + 32'd1;
        phase_d = sum - UnitStep;
      end else if ($signed(sum) <= -$signed(UnitStep)) begin
        pulse_o = 1'b1;
        dir_d   = 1'b0;
        count_d = count_q - 32'd1;
        phase_d = sum + UnitStep;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      count_q <= '0;
      dir_q   <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      dir_q   <= dir_d;
    end
  end

  assign dir_o   = dir_d;
  assign count_o = count_d;

  `SSSG_ASSERT_NEXT(a_idle_hold, clk_i, rst_ni, !adv_i,
    $stable(phase_q) && $stable(count_q) && $stable(dir_q), "state moved without advance")
  `SSSG_ASSERT_NEXT(a_count_step, clk_i, rst_ni, adv_i && pulse_o,
    (count_q == $past(count_q) + 32'd1) || (count_q == $past(count_q) - 32'd1),
    "step count did not move by one on a step")
  `SSSG_ASSERT_NEXT(a_no_step_count, clk_i, rst_ni, adv_i && !pulse_o,
    $stable(count_q) && $stable(dir_q), "count or direction moved without a step")
  `SSSG_ASSERT(a_off_no_step, clk_i, rst_ni, !work_i.step_en |-> !pulse_o,
    "step fired without tracking step tick")

endmodule

`default_nettype wire
